[src/zsp_pkg.sv]
// Zigzag swing point tracker: shared widths, constants and types.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package zsp_pkg;

    localparam int PRICE_WIDTH   = 32;
    localparam int INDEX_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int PROD_WIDTH = PRICE_WIDTH + FRACTION_BITS + 1;

    localparam logic [FRACTION_BITS-1:0] FRAC_RESET = FRACTION_BITS'(3277);
    localparam logic [FRACTION_BITS:0]   FRAC_ONE   = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

    localparam logic ACT_MOVE   = 1'b0;
    localparam logic ACT_APPEND = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] bar_index;
        logic [PRICE_WIDTH-1:0] bar_high;
        logic [PRICE_WIDTH-1:0] bar_low;
    } bar_t;

    typedef struct packed {
        logic                   action;
        logic [INDEX_WIDTH-1:0] point_bar;
        logic [PRICE_WIDTH-1:0] point_price;
        logic                   trend_after;
        logic                   last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage : zsp_pkg

`default_nettype wire

[src/zsp_bar_if.sv]
// Valid/ready channel carrying one price bar per beat.
// Depends on zsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface zsp_bar_if;
    import zsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] bar_index;
    logic [PRICE_WIDTH-1:0] bar_high;
    logic [PRICE_WIDTH-1:0] bar_low;

    modport source (output valid, output bar_index, output bar_high, output bar_low,
                    input ready);
    modport sink   (input valid, input bar_index, input bar_high, input bar_low,
                    output ready);
endinterface : zsp_bar_if

`default_nettype wire

[src/zsp_point_if.sv]
// Valid/ready channel carrying one swing point update per beat.
// Depends on zsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface zsp_point_if;
    import zsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [INDEX_WIDTH-1:0] point_bar;
    logic [PRICE_WIDTH-1:0] point_price;
    logic                   trend_after;
    logic                   last_of_run;

    modport source (output valid, output action, output point_bar, output point_price,
                    output trend_after, output last_of_run, input ready);
    modport sink   (input valid, input action, input point_bar, input point_price,
                    input trend_after, input last_of_run, output ready);
endinterface : zsp_point_if

`default_nettype wire

[src/zsp_tracker.sv]
// Swing point state and its combinational update for one registered bar.
// Depends on zsp_pkg; one shared threshold multiplier.
`timescale 1ns / 1ps
`default_nettype none

module zsp_tracker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            fire,
    input  wire zsp_pkg::bar_t             item,
    input  wire [zsp_pkg::FRACTION_BITS-1:0] frac,
    output zsp_pkg::push_t                 push
);
    import zsp_pkg::*;

    logic                   tracking_reg, tracking_next;
    logic                   trend_up_reg, trend_up_next;
    logic                   seen_reg, seen_next;
    logic [INDEX_WIDTH-1:0] swing_bar_reg, swing_bar_next;
    logic [PRICE_WIDTH-1:0] swing_price_reg, swing_price_next;
    logic [PRICE_WIDTH-1:0] run_low_reg, run_low_next;
    logic [INDEX_WIDTH-1:0] run_low_bar_reg, run_low_bar_next;
    logic [PRICE_WIDTH-1:0] run_high_reg, run_high_next;
    logic [INDEX_WIDTH-1:0] run_high_bar_reg, run_high_bar_next;

    logic [PRICE_WIDTH-1:0]     nl, nh;
    logic [INDEX_WIDTH-1:0]     nlb, nhb;
    logic [PRICE_WIDTH-1:0]     mul_a;
    logic [FRACTION_BITS:0]     mul_k;
    logic [PROD_WIDTH-1:0]      prod;
    logic [PROD_WIDTH-1:0]      hi_scaled;
    logic [PROD_WIDTH-1:0]      lo_scaled;
    logic [PRICE_WIDTH-1:0]     hi_sel;
    logic                       high_first;
    result_t                    hi_pt, lo_pt, one_pt;

    // running extremes as they stand after this bar
    always_comb
    begin
        if (!seen_reg || item.bar_low < run_low_reg)
        begin
            nl  = item.bar_low;
            nlb = item.bar_index;
        end
        else
        begin
            nl  = run_low_reg;
            nlb = run_low_bar_reg;
        end
        if (!seen_reg || item.bar_high > run_high_reg)
        begin
            nh  = item.bar_high;
            nhb = item.bar_index;
        end
        else
        begin
            nh  = run_high_reg;
            nhb = run_high_bar_reg;
        end
    end

    // shared threshold product: low*(1+t) seeking, swing*(1-t) up, swing*(1+t) down
    always_comb
    begin
        mul_a = tracking_reg ? swing_price_reg : nl;
        if (tracking_reg && trend_up_reg)
            mul_k = FRAC_ONE - {1'b0, frac};
        else
            mul_k = FRAC_ONE + {1'b0, frac};
        prod      = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_k);
        hi_sel    = tracking_reg ? item.bar_high : nh;
        hi_scaled = PROD_WIDTH'(hi_sel) << FRACTION_BITS;
        lo_scaled = PROD_WIDTH'(item.bar_low) << FRACTION_BITS;
    end

    always_comb
    begin
        tracking_next     = tracking_reg;
        trend_up_next     = trend_up_reg;
        seen_next         = seen_reg;
        swing_bar_next    = swing_bar_reg;
        swing_price_next  = swing_price_reg;
        run_low_next      = run_low_reg;
        run_low_bar_next  = run_low_bar_reg;
        run_high_next     = run_high_reg;
        run_high_bar_next = run_high_bar_reg;
        high_first        = !(nhb > nlb);

        hi_pt.action      = ACT_APPEND;
        hi_pt.point_bar   = nhb;
        hi_pt.point_price = nh;
        hi_pt.trend_after = !high_first;
        hi_pt.last_of_run = !high_first;
        lo_pt.action      = ACT_APPEND;
        lo_pt.point_bar   = nlb;
        lo_pt.point_price = nl;
        lo_pt.trend_after = !high_first;
        lo_pt.last_of_run = high_first;

        one_pt.action      = ACT_MOVE;
        one_pt.point_bar   = item.bar_index;
        one_pt.point_price = item.bar_low;
        one_pt.trend_after = trend_up_reg;
        one_pt.last_of_run = 1'b1;

        push.count  = 2'd0;
        push.first  = one_pt;
        push.second = one_pt;

        if (!tracking_reg)
        begin
            seen_next         = 1'b1;
            run_low_next      = nl;
            run_low_bar_next  = nlb;
            run_high_next     = nh;
            run_high_bar_next = nhb;
            if (hi_scaled > prod)
            begin
                tracking_next = 1'b1;
                trend_up_next = !high_first;
                push.count    = 2'd2;
                if (high_first)
                begin
                    push.first       = hi_pt;
                    push.second      = lo_pt;
                    swing_bar_next   = nlb;
                    swing_price_next = nl;
                end
                else
                begin
                    push.first       = lo_pt;
                    push.second      = hi_pt;
                    swing_bar_next   = nhb;
                    swing_price_next = nh;
                end
            end
        end
        else if (trend_up_reg)
        begin
            if (item.bar_high > swing_price_reg)
            begin
                swing_bar_next     = item.bar_index;
                swing_price_next   = item.bar_high;
                push.count         = 2'd1;
                push.first         = one_pt;
                push.first.point_price = item.bar_high;
            end
            else if (swing_bar_reg != item.bar_index && prod > lo_scaled)
            begin
                swing_bar_next     = item.bar_index;
                swing_price_next   = item.bar_low;
                trend_up_next      = 1'b0;
                push.count         = 2'd1;
                push.first         = one_pt;
                push.first.action  = ACT_APPEND;
                push.first.trend_after = 1'b0;
            end
        end
        else
        begin
            if (item.bar_low < swing_price_reg)
            begin
                swing_bar_next   = item.bar_index;
                swing_price_next = item.bar_low;
                push.count       = 2'd1;
                push.first       = one_pt;
            end
            else if (swing_bar_reg != item.bar_index && hi_scaled > prod)
            begin
                swing_bar_next     = item.bar_index;
                swing_price_next   = item.bar_high;
                trend_up_next      = 1'b1;
                push.count         = 2'd1;
                push.first         = one_pt;
                push.first.action  = ACT_APPEND;
                push.first.point_price = item.bar_high;
                push.first.trend_after = 1'b1;
            end
        end

        if (!fire)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg     <= 1'b0;
            trend_up_reg     <= 1'b0;
            seen_reg         <= 1'b0;
            swing_bar_reg    <= '0;
            swing_price_reg  <= '0;
            run_low_reg      <= '1;
            run_low_bar_reg  <= '0;
            run_high_reg     <= '0;
            run_high_bar_reg <= '0;
        end
        else if (fire)
        begin
            tracking_reg     <= tracking_next;
            trend_up_reg     <= trend_up_next;
            seen_reg         <= seen_next;
            swing_bar_reg    <= swing_bar_next;
            swing_price_reg  <= swing_price_next;
            run_low_reg      <= run_low_next;
            run_low_bar_reg  <= run_low_bar_next;
            run_high_reg     <= run_high_next;
            run_high_bar_reg <= run_high_bar_next;
        end
    end

    a_pair_enters_tracking: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |=> tracking_reg)
        else $error("two-point emit did not enter tracking");

    a_tracking_single: assert property (@(posedge clk) disable iff (!rst_n)
        tracking_reg |-> push.count != 2'd2)
        else $error("pair emitted while tracking");

    a_pair_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
        else $error("pair last_of_run marks wrong");

endmodule : zsp_tracker

`default_nettype wire

[src/zsp_out_queue.sv]
// Four-entry result queue; takes up to two results a cycle, gives one per beat.
// Depends on zsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsp_out_queue (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire zsp_pkg::push_t            push,
    input  wire                            pop,
    output zsp_pkg::result_t               head,
    output logic                           head_valid,
    output logic [zsp_pkg::QUEUE_CNT_W-1:0] count
);
    import zsp_pkg::*;

    result_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_plus1;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign count      = count_reg;
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.count);
        count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            slot_reg[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg + QUEUE_CNT_W'(push.count) <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QUEUE_PTR_W'(wr_ptr_reg - rd_ptr_reg) == QUEUE_PTR_W'(count_reg))
        else $error("queue pointers disagree with count");

endmodule : zsp_out_queue

`default_nettype wire

[src/zigzag_swing_point_tracker_core.sv]
// Top level of the percent-reversal zigzag swing point tracker.
// Depends on zsp_pkg, zsp_bar_if, zsp_point_if, zsp_tracker, zsp_out_queue.
//
// One bar is taken per cycle unless a held bar waits for queue room. A bar lands
// in an input register, is evaluated there against the swing state (one shared
// multiplier and two wide compares), and its results go into a four-entry queue
// that drives the point channel. A bar that completes the initial swing yields
// two beats (first the earlier point, high first on a tie); every other bar
// yields at most one, so with the output side always ready the block sustains
// one bar per cycle. The input register holds a bar while the queue has fewer
// than two free entries.
`timescale 1ns / 1ps
`default_nettype none

module zigzag_swing_point_tracker_core (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire [zsp_pkg::FRACTION_BITS-1:0] cfg_wr_data,
    zsp_bar_if.sink                          bars,
    zsp_point_if.source                      points
);
    import zsp_pkg::*;

    logic [FRACTION_BITS-1:0] frac_reg;
    bar_t                     item_reg;
    logic                     item_valid_reg, item_valid_next;
    logic                     fire;
    logic                     take;
    push_t                    push;
    result_t                  head;
    logic                     head_valid;
    logic [QUEUE_CNT_W-1:0]   q_count;

    assign fire        = item_valid_reg && (q_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign bars.ready  = !item_valid_reg || fire;
    assign take        = bars.valid && bars.ready;
    assign item_valid_next = take || (item_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg       <= FRAC_RESET;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                frac_reg <= cfg_wr_data;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.bar_index <= bars.bar_index;
            item_reg.bar_high  <= bars.bar_high;
            item_reg.bar_low   <= bars.bar_low;
        end
    end

    zsp_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .frac  (frac_reg),
        .push  (push)
    );

    zsp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (points.valid && points.ready),
        .head       (head),
        .head_valid (head_valid),
        .count      (q_count)
    );

    assign points.valid       = head_valid;
    assign points.action      = head.action;
    assign points.point_bar   = head.point_bar;
    assign points.point_price = head.point_price;
    assign points.trend_after = head.trend_after;
    assign points.last_of_run = head.last_of_run;

    a_fire_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> item_valid_reg)
        else $error("evaluated a bar that was not held");

    a_held_bar_stays: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !fire |=> item_valid_reg && $stable(item_reg))
        else $error("held bar lost or changed");

    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> item_valid_reg)
        else $error("accepted bar not registered");

endmodule : zigzag_swing_point_tracker_core

`default_nettype wire

[verif/zigzag_swing_point_tracker_core_tb.sv]
// Testbench for zigzag_swing_point_tracker_core: drives price bars over the bar
// channel and checks every swing point beat against an in-bench tracker model.
// Depends on zsp_pkg, zsp_bar_if, zsp_point_if and the core.
`timescale 1ns / 1ps

module zigzag_swing_point_tracker_core_tb;
    import zsp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [FRACTION_BITS-1:0] cfg_wr_data;

    zsp_bar_if   bar_ch();
    zsp_point_if point_ch();

    zigzag_swing_point_tracker_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bars        (bar_ch),
        .points      (point_ch)
    );

    // tracker model state
    logic [FRACTION_BITS-1:0] frac;
    logic                     tracking;
    logic                     rising;
    logic                     primed;
    logic [INDEX_WIDTH-1:0]   pivot_bar;
    logic [PRICE_WIDTH-1:0]   pivot_price;
    logic [PRICE_WIDTH-1:0]   lo_price;
    logic [INDEX_WIDTH-1:0]   lo_bar;
    logic [PRICE_WIDTH-1:0]   hi_price;
    logic [INDEX_WIDTH-1:0]   hi_bar;

    result_t pending_points[$];

    int errors;
    int bars_sent;
    int beats_seen;
    int appends_predicted;
    int moves_predicted;
    int silent_bars;
    int stall_cycles;
    int cycle_count;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_request;

    // random walk state
    longint                 walk_price;
    logic [INDEX_WIDTH-1:0] walk_idx;
    int                     walk_up_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("zigzag_swing_point_tracker_core test failed");
        $finish;
    end

    function automatic logic scaled_gt(input logic [PRICE_WIDTH-1:0] a,
                                       input logic [FRACTION_BITS:0] b,
                                       input logic [PRICE_WIDTH-1:0] c,
                                       input logic [FRACTION_BITS:0] d);
        return (PROD_WIDTH'(a) * PROD_WIDTH'(b)) > (PROD_WIDTH'(c) * PROD_WIDTH'(d));
    endfunction

    function automatic longint clamp_price(input longint v);
        if (v < 0)
            return 0;
        if (v > longint'(32'hFFFF_FFFF))
            return longint'(32'hFFFF_FFFF);
        return v;
    endfunction

    task automatic queue_point(input logic act, input logic [INDEX_WIDTH-1:0] pbar,
                               input logic [PRICE_WIDTH-1:0] pprice, input logic last);
        result_t r;
        r.action      = act;
        r.point_bar   = pbar;
        r.point_price = pprice;
        r.trend_after = rising;
        r.last_of_run = last;
        pending_points = {pending_points, r};
        if (act == ACT_APPEND)
            appends_predicted++;
        else
            moves_predicted++;
    endtask

    task automatic update_zigzag(input logic [INDEX_WIDTH-1:0] idx,
                                 input logic [PRICE_WIDTH-1:0] hi,
                                 input logic [PRICE_WIDTH-1:0] lo);
        logic [FRACTION_BITS:0] f_up;
        logic [FRACTION_BITS:0] f_dn;
        int                     queued_at_entry;
        f_up = FRAC_ONE + frac;
        f_dn = FRAC_ONE - frac;
        queued_at_entry = appends_predicted + moves_predicted;
        if (!tracking)
        begin
            if (!primed)
            begin
                lo_price = lo;
                lo_bar   = idx;
                hi_price = hi;
                hi_bar   = idx;
                primed   = 1'b1;
            end
            else
            begin
                if (lo < lo_price)
                begin
                    lo_price = lo;
                    lo_bar   = idx;
                end
                if (hi > hi_price)
                begin
                    hi_price = hi;
                    hi_bar   = idx;
                end
            end
            if (scaled_gt(hi_price, FRAC_ONE, lo_price, f_up))
            begin
                tracking = 1'b1;
                if (hi_bar > lo_bar)
                begin
                    rising = 1'b1;
                    queue_point(ACT_APPEND, lo_bar, lo_price, 1'b0);
                    queue_point(ACT_APPEND, hi_bar, hi_price, 1'b1);
                    pivot_bar   = hi_bar;
                    pivot_price = hi_price;
                end
                else
                begin
                    rising = 1'b0;
                    queue_point(ACT_APPEND, hi_bar, hi_price, 1'b0);
                    queue_point(ACT_APPEND, lo_bar, lo_price, 1'b1);
                    pivot_bar   = lo_bar;
                    pivot_price = lo_price;
                end
            end
        end
        else if (rising)
        begin
            if (hi > pivot_price)
            begin
                pivot_bar   = idx;
                pivot_price = hi;
                queue_point(ACT_MOVE, pivot_bar, pivot_price, 1'b1);
            end
            else if (pivot_bar != idx && scaled_gt(pivot_price, f_dn, lo, FRAC_ONE))
            begin
                pivot_bar   = idx;
                pivot_price = lo;
                rising      = 1'b0;
                queue_point(ACT_APPEND, pivot_bar, pivot_price, 1'b1);
            end
        end
        else
        begin
            if (lo < pivot_price)
            begin
                pivot_bar   = idx;
                pivot_price = lo;
                queue_point(ACT_MOVE, pivot_bar, pivot_price, 1'b1);
            end
            else if (pivot_bar != idx && scaled_gt(hi, FRAC_ONE, pivot_price, f_up))
            begin
                pivot_bar   = idx;
                pivot_price = hi;
                rising      = 1'b1;
                queue_point(ACT_APPEND, pivot_bar, pivot_price, 1'b1);
            end
        end
        if (appends_predicted + moves_predicted == queued_at_entry)
            silent_bars++;
    endtask

    task automatic send_bar(input logic [INDEX_WIDTH-1:0] idx,
                            input logic [PRICE_WIDTH-1:0] hi,
                            input logic [PRICE_WIDTH-1:0] lo);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            bar_ch.valid = 1'b0;
            @(negedge clk);
        end
        bar_ch.valid     = 1'b1;
        bar_ch.bar_index = idx;
        bar_ch.bar_high  = hi;
        bar_ch.bar_low   = lo;
        @(posedge clk);
        while (!bar_ch.ready)
            @(posedge clk);
        bars_sent++;
        update_zigzag(idx, hi, lo);
    endtask

    task automatic wait_points_done();
        @(negedge clk);
        bar_ch.valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_fraction(input logic [FRACTION_BITS-1:0] value);
        wait_points_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        frac      = value;
    endtask

    task automatic send_walk_bar();
        int unsigned pick;
        longint      spread;
        longint      step;
        longint      hi;
        longint      lo;
        pick = $urandom_range(99);
        if (pick < 2)
            walk_price = longint'($urandom);
        else if (pick < 3)
            walk_price = $urandom_range(255);
        if ($urandom_range(19) == 0)
            walk_up_pct = 100 - walk_up_pct;
        // 6..11: bar index repeated with new prices
        if (pick < 6 || pick >= 12)
            walk_idx++;
        spread = (walk_price >> $urandom_range(3, 9)) + 1;
        step   = $urandom_range(32'(spread));
        if ($urandom_range(99) < walk_up_pct)
            walk_price = clamp_price(walk_price + step);
        else
            walk_price = clamp_price(walk_price - step);
        hi = clamp_price(walk_price + $urandom_range(32'(spread)));
        lo = clamp_price(walk_price - $urandom_range(32'(spread)));
        if (pick < 6)
            send_bar($urandom, $urandom, $urandom);
        else
            send_bar(walk_idx, hi[PRICE_WIDTH-1:0], lo[PRICE_WIDTH-1:0]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // point channel sink: random stalls plus requested hold-offs
    initial
    begin : point_sink
        int hold_left;
        hold_left      = 0;
        point_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                point_ch.ready = 1'b0;
                hold_left--;
            end
            else
                point_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin : point_checker
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (bar_ch.valid && !bar_ch.ready)
                    stall_cycles++;
                if (point_ch.valid && point_ch.ready)
                begin
                    beats_seen++;
                    if (pending_points.size() == 0)
                    begin
                        errors++;
                        $display("%0t: unexpected point beat, expected none, actual bar %h price %h",
                                 $time, point_ch.point_bar, point_ch.point_price);
                    end
                    else
                    begin
                        want = pending_points.pop_front();
                        check_field("action", want.action, point_ch.action);
                        check_field("point_bar", want.point_bar, point_ch.point_bar);
                        check_field("point_price", want.point_price, point_ch.point_price);
                        check_field("trend_after", want.trend_after, point_ch.trend_after);
                        check_field("last_of_run", want.last_of_run, point_ch.last_of_run);
                    end
                end
            end
        end
    end

    // first bar, ties, threshold not met, then one of the three ways to leave seeking
    task automatic test_seeking();
        send_bar(32'd100, 32'd1000, 32'd990);
        send_bar(32'd101, 32'd1000, 32'd990);
        send_bar(32'd102, 32'd995, 32'd992);
        case ($urandom_range(2))
            0: send_bar(32'd103, 32'd990, 32'd900);
            1: send_bar(32'd103, 32'd1100, 32'd995);
            default: send_bar(32'd100, 32'd1100, 32'd900);
        endcase
    endtask

    // extension, own-bar reversal, quiet bar, reversals, price and index extremes
    task automatic test_tracking_cases();
        send_bar(32'd200, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_bar(32'd200, 32'd5, 32'd0);
        send_bar(32'd201, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_bar(32'd202, 32'd100, 32'd0);
        send_bar(32'd203, 32'd0, 32'd0);
        send_bar(32'hFFFF_FFFF, 32'd1, 32'd0);
        send_bar(32'd0, 32'd3, 32'd1);
    endtask

    task automatic test_threshold_extremes();
        write_fraction('0);
        send_bar(32'd1, 32'd3, 32'd2);
        send_bar(32'd2, 32'd2, 32'd2);
        send_bar(32'd3, 32'd3, 32'd2);
        write_fraction('1);
        send_bar(32'd4, 32'd3, 32'd1);
        send_bar(32'd5, 32'd3, 32'd0);
        send_bar(32'd6, 32'd1, 32'd0);
    endtask

    task automatic test_random_walk(input logic [FRACTION_BITS-1:0] fraction,
                                    input int count, input logic [INDEX_WIDTH-1:0] first_idx);
        write_fraction(fraction);
        walk_idx = first_idx;
        repeat (count) send_walk_bar();
    endtask

    // sink holds off while bars keep coming, so the queue fills and input stalls
    task automatic test_backpressure();
        src_idle_pct = 0;
        @(negedge clk);
        bar_ch.valid = 1'b0;
        hold_request = 80;
        repeat (50) send_walk_bar();
        src_idle_pct = 16;
    endtask

    task automatic test_no_idle();
        write_fraction(16'd655);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (100) send_walk_bar();
        src_idle_pct  = 16;
        sink_idle_pct = 16;
    endtask

    task automatic test_drain_pause();
        repeat (30) send_walk_bar();
        wait_points_done();
        repeat (30) send_walk_bar();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        bar_ch.valid     = 1'b0;
        bar_ch.bar_index = '0;
        bar_ch.bar_high  = '0;
        bar_ch.bar_low   = '0;
        errors           = 0;
        bars_sent        = 0;
        beats_seen       = 0;
        appends_predicted = 0;
        moves_predicted  = 0;
        silent_bars      = 0;
        stall_cycles     = 0;
        cycle_count      = 0;
        src_idle_pct     = 16;
        sink_idle_pct    = 16;
        hold_request     = 0;
        walk_price       = 32'd50000;
        walk_idx         = '0;
        walk_up_pct      = 65;
        frac             = FRAC_RESET;
        tracking         = 1'b0;
        rising           = 1'b0;
        primed           = 1'b0;
        pivot_bar        = '0;
        pivot_price      = '0;
        lo_price         = '1;
        lo_bar           = '0;
        hi_price         = '0;
        hi_bar           = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_seeking();
        test_tracking_cases();
        test_threshold_extremes();
        test_random_walk(FRAC_RESET, 150, $urandom);
        test_backpressure();
        test_random_walk('0, 100, 32'hFFFF_FF80);
        test_no_idle();
        test_random_walk('1, 100, $urandom);
        test_drain_pause();
        test_random_walk(FRACTION_BITS'($urandom), 120, $urandom);

        wait_points_done();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d bars, %0d point beats (%0d appended, %0d moved), %0d bars silent",
                 bars_sent, beats_seen, appends_predicted, moves_predicted, silent_bars);
        $display("summary: thresholds reset/zero/full/1%%/random, %0d input stall cycles",
                 stall_cycles);
        if (errors == 0)
            $display("zigzag_swing_point_tracker_core test passed");
        else
            $display("zigzag_swing_point_tracker_core test failed");
        $finish;
    end

endmodule

[files.f]
src/zsp_pkg.sv
src/zsp_bar_if.sv
src/zsp_point_if.sv
src/zsp_tracker.sv
src/zsp_out_queue.sv
src/zigzag_swing_point_tracker_core.sv
verif/zigzag_swing_point_tracker_core_tb.sv
